### design/sha_bsh_pkg.sv
// Shared types, round constants and SHA-256 helper functions for the hasher.
package sha_bsh_pkg;

  // Control from the sequencer to the round datapath
  typedef struct packed {
    logic       take_mem;   // next schedule word comes from the block buffer
    logic       shift;      // advance the schedule shift line
    logic       wv_load;    // copy hash words into the working variables
    logic       round;      // run one compression round
    logic       fold;       // add working variables into hash words
    logic       hash_init;  // restore the initial hash values
    logic [5:0] rnd;        // current round
    logic [2:0] out_idx;    // digest word to present
  } core_ctl_t;

  localparam logic [5:0] LAST_RND = 6'd63;
  localparam logic [2:0] LAST_WORD = 3'd7;
  localparam logic [7:0] PAD_MARK = 8'h80;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  // Initial hash values
  function automatic logic [31:0] init_hash(input logic [2:0] i);
    case (i)
      3'd0: init_hash = 32'h6a09e667;
      3'd1: init_hash = 32'hbb67ae85;
      3'd2: init_hash = 32'h3c6ef372;
      3'd3: init_hash = 32'ha54ff53a;
      3'd4: init_hash = 32'h510e527f;
      3'd5: init_hash = 32'h9b05688c;
      3'd6: init_hash = 32'h1f83d9ab;
      default: init_hash = 32'h5be0cd19;
    endcase
  endfunction

  // Round constants
  function automatic logic [31:0] round_k(input logic [5:0] r);
    case (r)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
      default: round_k = 32'h0;
    endcase
  endfunction

endpackage

### design/sha_bsh_buf.sv
// Block buffer: 16 x 32-bit synchronous RAM, one write and one registered read port.
module sha_bsh_buf (
  input  logic        clk,
  input  logic        we,
  input  logic [3:0]  waddr,
  input  logic [31:0] wdata,
  input  logic [3:0]  raddr,
  output logic [31:0] rdata
);

  logic [31:0] mem [16];

  // Write the addressed word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### design/sha_bsh_core.sv
// Round datapath: message schedule line, working variables and hash words.
module sha_bsh_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sha_bsh_pkg::core_ctl_t ctl,
  input  logic [31:0]           mem_rdata,
  output logic [31:0]           digest_word
);

  logic [31:0] w_sr_r [16];
  logic [31:0] wv_r [8];
  logic [31:0] hash_r [8];
  logic [31:0] w_calc;
  logic [31:0] w_in;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  // Expand the schedule: taps hold W[r-1], W[r-6], W[r-14], W[r-15] for W[r+1]
  assign w_calc = sha_bsh_pkg::ssig1(w_sr_r[14]) + w_sr_r[9]
                + sha_bsh_pkg::ssig0(w_sr_r[1]) + w_sr_r[0];
  assign w_in = ctl.take_mem ? mem_rdata : w_calc;

  // One compression round on the newest schedule word
  assign ch  = (wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]);
  assign maj = (wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]);
  assign t1  = wv_r[7] + sha_bsh_pkg::bsig1(wv_r[4]) + ch
             + sha_bsh_pkg::round_k(ctl.rnd) + w_sr_r[15];
  assign t2  = sha_bsh_pkg::bsig0(wv_r[0]) + maj;

  assign digest_word = hash_r[ctl.out_idx];

  // Advance the schedule line
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      for (int i = 0; i < 15; i++) begin
        w_sr_r[i] <= w_sr_r[i + 1];
      end
      w_sr_r[15] <= w_in;
    end
  end

  // Load or rotate the working variables
  always_ff @(posedge clk) begin
    if (ctl.wv_load) begin
      for (int i = 0; i < 8; i++) begin
        wv_r[i] <= hash_r[i];
      end
    end else if (ctl.round) begin
      wv_r[7] <= wv_r[6];
      wv_r[6] <= wv_r[5];
      wv_r[5] <= wv_r[4];
      wv_r[4] <= wv_r[3] + t1;
      wv_r[3] <= wv_r[2];
      wv_r[2] <= wv_r[1];
      wv_r[1] <= wv_r[0];
      wv_r[0] <= t1 + t2;
    end
  end

  // Hold the chaining value; restore it after each digest
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.hash_init) begin
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= sha_bsh_pkg::init_hash(3'(i));
      end
    end else if (ctl.fold) begin
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= hash_r[i] + wv_r[i];
      end
    end
  end

endmodule

### design/sha256_byte_stream_hasher.sv
// SHA-256 byte-stream hasher top level: input packing, padding and block sequencing.
//
// Bytes enter one per cycle and are packed big-endian into a 16-word block buffer RAM.
// When the 64th byte of a block arrives, input stalls while S_LD0 and S_LD1 prime
// the buffer read, 64 rounds run at one per cycle on a single round unit, and S_FOLD
// adds the result into the hash. An end-of-message transaction writes the rest of the
// block with padding and length (16 minus the filled word count, one word per cycle),
// runs one compression, or two when fewer than nine bytes of room remain, and then
// presents the eight digest words as eight output transactions, word 0 first. Input is
// held off from the end-of-message transaction until the last digest word is taken.
module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LD0,
    S_LD1,
    S_RND,
    S_FOLD,
    S_OUT
  } state_t;

  state_t      state_r, state_nxt;
  logic [63:0] cnt_r, cnt_nxt;
  logic [23:0] pack_r, pack_nxt;
  logic [3:0]  pw_r, pw_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  oidx_r, oidx_nxt;
  logic        mark_done_r, mark_done_nxt;
  logic        len_here_r, len_here_nxt;
  logic        final_r, final_nxt;
  logic        pend_end_r, pend_end_nxt;
  logic        more_r, more_nxt;

  logic        in_acc;
  logic        out_acc;
  logic [63:0] bit_len;
  logic [31:0] pad_word;
  logic        buf_we;
  logic [3:0]  buf_waddr;
  logic [31:0] buf_wdata;
  logic [3:0]  buf_raddr;
  logic [31:0] buf_rdata;
  sha_bsh_pkg::core_ctl_t ctl;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign bit_len = {cnt_r[60:0], 3'b000};

  // Build the padding word for the current pad slot
  always_comb begin
    pad_word = '0;
    if (!mark_done_r && pw_r == cnt_r[5:2]) begin
      case (cnt_r[1:0])
        2'd0: pad_word = {sha_bsh_pkg::PAD_MARK, 24'h0};
        2'd1: pad_word = {pack_r[7:0], sha_bsh_pkg::PAD_MARK, 16'h0};
        2'd2: pad_word = {pack_r[15:0], sha_bsh_pkg::PAD_MARK, 8'h0};
        default: pad_word = {pack_r, sha_bsh_pkg::PAD_MARK};
      endcase
    end else if (len_here_r && pw_r == 4'd14) begin
      pad_word = bit_len[63:32];
    end else if (len_here_r && pw_r == 4'd15) begin
      pad_word = bit_len[31:0];
    end
  end

  // Sequence filling, padding, compression and digest output
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pack_nxt      = pack_r;
    pw_nxt        = pw_r;
    rnd_nxt       = rnd_r;
    oidx_nxt      = oidx_r;
    mark_done_nxt = mark_done_r;
    len_here_nxt  = len_here_r;
    final_nxt     = final_r;
    pend_end_nxt  = pend_end_r;
    more_nxt      = more_r;
    buf_we        = 1'b0;
    buf_waddr     = pw_r;
    buf_wdata     = pad_word;
    ctl           = '0;
    ctl.rnd       = rnd_r;
    ctl.out_idx   = oidx_r;
    buf_raddr     = 4'd0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_has_byte) begin
            pack_nxt = {pack_r[15:0], in_data_byte};
            cnt_nxt  = cnt_r + 64'd1;
            if (cnt_r[1:0] == 2'd3) begin
              buf_we    = 1'b1;
              buf_waddr = cnt_r[5:2];
              buf_wdata = {pack_r, in_data_byte};
            end
          end
          mark_done_nxt = 1'b0;
          len_here_nxt  = cnt_nxt[5:2] < 4'd14;
          pw_nxt        = cnt_nxt[5:2];
          if (in_has_byte && cnt_r[5:0] == 6'd63) begin
            // Block full: compress, then pad if this was the end
            state_nxt    = S_LD0;
            final_nxt    = 1'b0;
            more_nxt     = 1'b0;
            pend_end_nxt = in_end_of_message;
          end else if (in_end_of_message) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        buf_we = 1'b1;
        pw_nxt = pw_r + 4'd1;
        if (pw_r == 4'd15) begin
          state_nxt    = S_LD0;
          final_nxt    = len_here_r;
          more_nxt     = !len_here_r;
          pend_end_nxt = 1'b0;
        end
      end
      S_LD0: begin
        buf_raddr = 4'd0;
        state_nxt = S_LD1;
      end
      S_LD1: begin
        buf_raddr    = 4'd1;
        ctl.take_mem = 1'b1;
        ctl.shift    = 1'b1;
        ctl.wv_load  = 1'b1;
        rnd_nxt      = '0;
        state_nxt    = S_RND;
      end
      S_RND: begin
        buf_raddr    = rnd_r[3:0] + 4'd2;
        ctl.take_mem = rnd_r < 6'd15;
        ctl.shift    = 1'b1;
        ctl.round    = 1'b1;
        rnd_nxt      = rnd_r + 6'd1;
        if (rnd_r == sha_bsh_pkg::LAST_RND) begin
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        ctl.fold = 1'b1;
        pw_nxt   = 4'd0;
        if (final_r) begin
          oidx_nxt  = '0;
          state_nxt = S_OUT;
        end else if (pend_end_r) begin
          // End arrived with the byte that filled the block
          mark_done_nxt = 1'b0;
          len_here_nxt  = 1'b1;
          pend_end_nxt  = 1'b0;
          state_nxt     = S_PAD;
        end else if (more_r) begin
          // Length did not fit: one more block of zeros and length
          mark_done_nxt = 1'b1;
          len_here_nxt  = 1'b1;
          more_nxt      = 1'b0;
          state_nxt     = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == sha_bsh_pkg::LAST_WORD) begin
            ctl.hash_init = 1'b1;
            cnt_nxt       = '0;
            final_nxt     = 1'b0;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pw_r        <= '0;
      rnd_r       <= '0;
      oidx_r      <= '0;
      mark_done_r <= 1'b0;
      len_here_r  <= 1'b0;
      final_r     <= 1'b0;
      pend_end_r  <= 1'b0;
      more_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pw_r        <= pw_nxt;
      rnd_r       <= rnd_nxt;
      oidx_r      <= oidx_nxt;
      mark_done_r <= mark_done_nxt;
      len_here_r  <= len_here_nxt;
      final_r     <= final_nxt;
      pend_end_r  <= pend_end_nxt;
      more_r      <= more_nxt;
    end
  end

  // Hold partial word bytes
  always_ff @(posedge clk) begin
    pack_r <= pack_nxt;
  end

  assign in_ready        = state_r == S_IDLE;
  assign out_valid       = state_r == S_OUT;
  assign out_word_index  = oidx_r;
  assign out_last_word   = oidx_r == sha_bsh_pkg::LAST_WORD;

  sha_bsh_buf u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  sha_bsh_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .mem_rdata   (buf_rdata),
    .digest_word (out_digest_word)
  );

  // Input and output never share a cycle
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input ready while digest is presented");

  // Buffer writes happen only while filling or padding
  a_buf_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    buf_we |-> (state_r == S_IDLE || state_r == S_PAD))
    else $error("block buffer written during compression");

  // Rounds advance one per cycle
  a_round_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RND && rnd_r != sha_bsh_pkg::LAST_RND) |=>
      (state_r == S_RND && rnd_r == $past(rnd_r) + 6'd1))
    else $error("round counter skipped");

  // Last digest word clears the byte count
  a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_word) |=> (cnt_r == 64'd0 && in_ready))
    else $error("message state not cleared after digest");

endmodule
